### sv/screen_tint_and_flash_fader_macros.svh
// Assertion helpers shared by the fader RTL.
// Both macros expect the including module to have clk_i and rst_ni.
`ifndef SCREEN_TINT_AND_FLASH_FADER_MACROS_SVH
`define SCREEN_TINT_AND_FLASH_FADER_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define STFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside of reset.
`define STFF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/stff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stff_pkg;

  // Default width of the frame countdowns.
  localparam int unsigned FrameBitsDef = 16;

  // Tint channels: red, green, blue, alpha.
  localparam int unsigned NumChan  = 4;
  localparam int unsigned ChanBits = $clog2(NumChan);
  localparam logic [ChanBits-1:0] LastChan = ChanBits'(NumChan - 1);

  // Shared divider: an 8-bit quotient, two quotient bits per cycle.
  localparam int unsigned DivQuoBits     = 8;
  localparam int unsigned DivBitsPerStep = 2;
  localparam int unsigned DivSteps       = DivQuoBits / DivBitsPerStep;
  localparam int unsigned DivCntBits     = $clog2(DivSteps);

  localparam logic [7:0] FullLevel = 8'hFF;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_TINT     = 3'd1,
    CMD_FADE_IN  = 3'd2,
    CMD_FADE_OUT = 3'd3,
    CMD_FLASH    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TINT_GO,
    S_TINT_WAIT,
    S_FLASH_CHK,
    S_FLASH_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [15:0] frames;
  } in_t;

  typedef struct packed {
    logic [7:0] tint_red;
    logic [7:0] tint_green;
    logic [7:0] tint_blue;
    logic [7:0] tint_alpha;
    logic       tint_busy;
    logic [7:0] flash_red;
    logic [7:0] flash_green;
    logic [7:0] flash_blue;
    logic [7:0] flash_level;
    logic       flash_visible;
  } out_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### sv/screen_tint_and_flash_fader.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  stff_pkg::in_t  (command, colors, frames)
// out       output     out_valid_o/ out_ready_i stff_pkg::out_t (tint and flash state)
//
// A command transaction goes from acceptance through the output state back to idle.
// A tick runs four channel divisions on the shared divider while a tint runs, then
// checks the flash and runs one more division when the flash level needs one.
// Each division yields two quotient bits per cycle.
// Reset clears all tint and flash state to zero (transparent black, no effect running).
// A result that is not taken holds the sequencer in its output state; a new
// transaction is still accepted while the previous result waits.

module screen_tint_and_flash_fader #(
  parameter int unsigned FRAME_BITS = stff_pkg::FrameBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire stff_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output stff_pkg::out_t       out_data_o
);

  `include "screen_tint_and_flash_fader_macros.svh"

  localparam int unsigned NumW = FRAME_BITS + stff_pkg::DivQuoBits;
  localparam int unsigned CB   = stff_pkg::ChanBits;
  // Largest countdown value; longer durations saturate here.
  localparam logic [32:0] FrameMax = 33'((64'd1 << FRAME_BITS) - 64'd1);

  stff_pkg::state_e state_q, state_d;

  // Architectural state. Channel index 0 is red, 3 is alpha.
  logic [stff_pkg::NumChan-1:0][7:0] now_q, now_d;
  logic [stff_pkg::NumChan-1:0][7:0] goal_q, goal_d;
  logic [2:0][7:0]                   fcol_q, fcol_d;
  logic [7:0]                        flevel_q, flevel_d;
  logic [FRAME_BITS-1:0]             tleft_q, tleft_d;
  logic [FRAME_BITS-1:0]             fleft_q, fleft_d;
  logic [FRAME_BITS-1:0]             fmid_q, fmid_d;
  logic [CB-1:0]                     ch_q, ch_d;

  stff_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  // Command decode and duration limits.
  stff_pkg::cmd_e cmd;
  logic [32:0]    raw_ext, half_ext;
  logic [FRAME_BITS-1:0] frames_lim, mid_lim;
  logic           frames_nz;
  logic [stff_pkg::NumChan-1:0][7:0] col, src_col, base_now;
  logic           tint_ok;

  assign cmd       = stff_pkg::cmd_e'(in_data_i.command);
  assign raw_ext   = 33'(in_data_i.frames);
  assign half_ext  = (raw_ext + 33'd1) >> 1;
  assign frames_lim = (raw_ext > FrameMax) ? FrameMax[FRAME_BITS-1:0] : raw_ext[FRAME_BITS-1:0];
  assign mid_lim   = (half_ext > FrameMax) ? FrameMax[FRAME_BITS-1:0] : half_ext[FRAME_BITS-1:0];
  assign frames_nz = (in_data_i.frames != '0);

  // Fade out always heads to an opaque color.
  assign col = {(cmd == stff_pkg::CMD_FADE_OUT) ? stff_pkg::FullLevel : in_data_i.alpha,
                in_data_i.blue, in_data_i.green, in_data_i.red};
  assign src_col = {stff_pkg::FullLevel, in_data_i.src_blue, in_data_i.src_green,
                    in_data_i.src_red};
  // A fade in first jumps to its opaque start color, then tints from there.
  assign base_now = (cmd == stff_pkg::CMD_FADE_IN) ? src_col : now_q;
  assign tint_ok  = frames_nz && (base_now != col);

  // Tint channel step: move by (goal - now) / left, truncated toward zero.
  logic [7:0] goal_c, now_c, mag_c, tint_next;
  logic       neg_c;

  assign goal_c    = goal_q[ch_q];
  assign now_c     = now_q[ch_q];
  assign neg_c     = (goal_c < now_c);
  assign mag_c     = neg_c ? (now_c - goal_c) : (goal_c - now_c);

  // Flash triangle: level = 255 * (mid - |left - mid|) / mid.
  logic [FRAME_BITS-1:0] fdist, fspan;
  logic                  flash_need;

  assign fdist      = (fleft_q > fmid_q) ? (fleft_q - fmid_q) : (fmid_q - fleft_q);
  assign fspan      = fmid_q - fdist;
  assign flash_need = (fmid_q != '0) && (fdist <= fmid_q);

  // Shared divider. Operands are picked by the sequencer state.
  logic                  div_start;
  logic [NumW-1:0]       div_dividend;
  logic [FRAME_BITS-1:0] div_divisor;
  logic [7:0]            div_quo;
  stff_pkg::div_stat_t   div_stat;

  always_comb begin
    if (state_q == stff_pkg::S_FLASH_CHK) begin
      // Multiply by 255 as a shift and a subtract.
      div_dividend = {fspan, 8'h00} - NumW'(fspan);
      div_divisor  = fmid_q;
    end else begin
      div_dividend = NumW'(mag_c);
      div_divisor  = tleft_q;
    end
  end

  stff_div #(
    .FRAME_BITS (FRAME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign tint_next = neg_c ? (now_c - div_quo) : (now_c + div_quo);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == stff_pkg::S_IDLE);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stff_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (cmd == stff_pkg::CMD_TICK) begin
            state_d = (tleft_q != '0) ? stff_pkg::S_TINT_GO : stff_pkg::S_FLASH_CHK;
          end else begin
            state_d = stff_pkg::S_OUT;
          end
        end
      end
      stff_pkg::S_TINT_GO: begin
        state_d = stff_pkg::S_TINT_WAIT;
      end
      stff_pkg::S_TINT_WAIT: begin
        if (div_stat.done) begin
          state_d = (ch_q == stff_pkg::LastChan) ? stff_pkg::S_FLASH_CHK
                                                 : stff_pkg::S_TINT_GO;
        end
      end
      stff_pkg::S_FLASH_CHK: begin
        state_d = (fleft_q != '0 && flash_need) ? stff_pkg::S_FLASH_WAIT : stff_pkg::S_OUT;
      end
      stff_pkg::S_FLASH_WAIT: begin
        if (div_stat.done) begin
          state_d = stff_pkg::S_OUT;
        end
      end
      stff_pkg::S_OUT: begin
        if (out_free) begin
          state_d = stff_pkg::S_IDLE;
        end
      end
      default: state_d = stff_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and divider control.
  always_comb begin
    now_d     = now_q;
    goal_d    = goal_q;
    tleft_d   = tleft_q;
    fcol_d    = fcol_q;
    flevel_d  = flevel_q;
    fleft_d   = fleft_q;
    fmid_d    = fmid_q;
    ch_d      = ch_q;
    div_start = 1'b0;
    unique case (state_q)
      stff_pkg::S_IDLE: begin
        ch_d = '0;
        if (in_valid_i) begin
          unique case (cmd) inside
            stff_pkg::CMD_TINT, stff_pkg::CMD_FADE_OUT: begin
              if (tint_ok) begin
                goal_d  = col;
                tleft_d = frames_lim;
              end
            end
            stff_pkg::CMD_FADE_IN: begin
              if (frames_nz) begin
                now_d = src_col;
                if (tint_ok) begin
                  goal_d  = col;
                  tleft_d = frames_lim;
                end
              end
            end
            stff_pkg::CMD_FLASH: begin
              if (frames_nz) begin
                fcol_d   = {in_data_i.blue, in_data_i.green, in_data_i.red};
                flevel_d = '0;
                fleft_d  = frames_lim;
                fmid_d   = mid_lim;
              end
            end
            default: begin
              // A tick does its work in the states that follow; other codes do nothing.
            end
          endcase
        end
      end
      stff_pkg::S_TINT_GO: begin
        div_start = 1'b1;
      end
      stff_pkg::S_TINT_WAIT: begin
        if (div_stat.done) begin
          now_d[ch_q] = tint_next;
          if (ch_q == stff_pkg::LastChan) begin
            tleft_d = tleft_q - FRAME_BITS'(1);
          end else begin
            ch_d = ch_q + CB'(1);
          end
        end
      end
      stff_pkg::S_FLASH_CHK: begin
        if (fleft_q != '0) begin
          if (flash_need) begin
            div_start = 1'b1;
          end else begin
            flevel_d = '0;
            fleft_d  = fleft_q - FRAME_BITS'(1);
          end
        end
      end
      stff_pkg::S_FLASH_WAIT: begin
        if (div_stat.done) begin
          flevel_d = div_quo;
          fleft_d  = fleft_q - FRAME_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a snapshot of the state once the transaction is finished.
  always_comb begin
    out_d.tint_red      = now_q[0];
    out_d.tint_green    = now_q[1];
    out_d.tint_blue     = now_q[2];
    out_d.tint_alpha    = now_q[3];
    out_d.tint_busy     = (tleft_q != '0);
    out_d.flash_red     = fcol_q[0];
    out_d.flash_green   = fcol_q[1];
    out_d.flash_blue    = fcol_q[2];
    out_d.flash_level   = flevel_q;
    out_d.flash_visible = (fleft_q != '0);
    if (state_q == stff_pkg::S_OUT && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stff_pkg::S_IDLE;
      now_q       <= '0;
      goal_q      <= '0;
      tleft_q     <= '0;
      fcol_q      <= '0;
      flevel_q    <= '0;
      fleft_q     <= '0;
      fmid_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      goal_q      <= goal_d;
      tleft_q     <= tleft_d;
      fcol_q      <= fcol_d;
      flevel_q    <= flevel_d;
      fleft_q     <= fleft_d;
      fmid_q      <= fmid_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == stff_pkg::S_OUT && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `STFF_ASSERT(a_tleft_step, (state_q == stff_pkg::S_TINT_WAIT && div_stat.done && ch_q == stff_pkg::LastChan) |=> (tleft_q == $past(tleft_q) - FRAME_BITS'(1)), "tint countdown did not drop by one")
  `STFF_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> ($past(state_q) == stff_pkg::S_OUT), "result appeared outside the output state")
  `STFF_ASSERT(a_done_in_wait, div_stat.done |-> (state_q == stff_pkg::S_TINT_WAIT || state_q == stff_pkg::S_FLASH_WAIT), "divider finished outside a wait")
  `STFF_NEVER(a_idle_div, (state_q == stff_pkg::S_IDLE) && div_stat.busy, "divider busy while idle")

endmodule

`default_nettype wire

### sv/stff_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for quotients known to fit in DivQuoBits bits.
// The divisor is pre-shifted to the top quotient bit and walks right.
module stff_div #(
  parameter int unsigned FRAME_BITS = stff_pkg::FrameBitsDef
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         start_i,
  input  wire logic [FRAME_BITS+stff_pkg::DivQuoBits-1:0]   dividend_i,
  input  wire logic [FRAME_BITS-1:0]                        divisor_i,
  output logic      [stff_pkg::DivQuoBits-1:0]              quotient_o,
  output stff_pkg::div_stat_t                               stat_o
);

  `include "screen_tint_and_flash_fader_macros.svh"

  localparam int unsigned NumW = FRAME_BITS + stff_pkg::DivQuoBits;
  localparam int unsigned QB   = stff_pkg::DivQuoBits;

  logic [NumW-1:0] rem_q, rem_d, ds_q, ds_d;
  logic [QB-1:0]   quo_q, quo_d;
  logic [stff_pkg::DivCntBits-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic            last_step;

  assign last_step = (cnt_q == stff_pkg::DivCntBits'(stff_pkg::DivSteps - 1));

  always_comb begin
    logic [NumW-1:0] rem_n;
    logic [NumW-1:0] ds_n;
    logic [QB-1:0]   quo_n;
    rem_n  = rem_q;
    ds_n   = ds_q;
    quo_n  = quo_q;
    rem_d  = rem_q;
    ds_d   = ds_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      ds_d   = NumW'(divisor_i) << (QB - 1);
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int j = 0; j < int'(stff_pkg::DivBitsPerStep); j++) begin
        if (rem_n >= ds_n) begin
          rem_n = rem_n - ds_n;
          quo_n = {quo_n[QB-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[QB-2:0], 1'b0};
        end
        ds_n = ds_n >> 1;
      end
      rem_d = rem_n;
      ds_d  = ds_n;
      quo_d = quo_n;
      cnt_d = cnt_q + stff_pkg::DivCntBits'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ds_q  <= ds_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `STFF_NEVER(a_div_restart, start_i && busy_q, "divider started while busy")
  `STFF_NEVER(a_div_zero, start_i && (divisor_i == '0), "divider started with zero divisor")
  `STFF_ASSERT(a_div_done, (busy_q && last_step && !start_i) |=> (done_q && !busy_q), "divider did not finish")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

import stff_pkg::*;

// Tracks the overlay state the fader should hold and keeps the results that
// are owed for transactions already accepted on the input side.
class overlay_tracker;
  localparam int unsigned ReportCap = 100;

  // Channel index 0 is red, 1 green, 2 blue, 3 alpha.
  logic [3:0][7:0] tint_now;
  logic [3:0][7:0] tint_goal;
  logic [15:0]     tint_left;
  logic [2:0][7:0] flash_rgb;
  logic [7:0]      flash_level;
  logic [15:0]     flash_left;
  logic [15:0]     flash_mid;

  out_t        overlay_due_q[$];
  int unsigned mismatches;
  int unsigned results_seen;

  function new();
    tint_now     = '0;
    tint_goal    = '0;
    tint_left    = '0;
    flash_rgb    = '0;
    flash_level  = '0;
    flash_left   = '0;
    flash_mid    = '0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  function int unsigned pending();
    return overlay_due_q.size();
  endfunction

  // A fade only starts when it has frames to run and somewhere to go.
  function void begin_tint(logic [3:0][7:0] goal, logic [15:0] frames);
    if (frames != '0 && goal != tint_now) begin
      tint_goal = goal;
      tint_left = frames;
    end
  endfunction

  function void advance_frame();
    int          diff;
    int          step;
    int          sum;
    int unsigned left_u;
    int unsigned mid_u;
    int unsigned gap;
    int unsigned lvl;
    if (tint_left != '0) begin
      for (int c = 0; c < 4; c++) begin
        // Signed division in SystemVerilog truncates toward zero.
        diff = int'(tint_goal[c]) - int'(tint_now[c]);
        step = diff / int'(tint_left);
        sum = int'(tint_now[c]) + step;
        tint_now[c] = sum[7:0];
      end
      tint_left = tint_left - 16'd1;
    end
    if (flash_left != '0) begin
      left_u = flash_left;
      mid_u = flash_mid;
      gap = (left_u > mid_u) ? left_u - mid_u : mid_u - left_u;
      lvl = 0;
      if (mid_u != 0 && gap <= mid_u) begin
        lvl = (255 * (mid_u - gap)) / mid_u;
      end
      if (lvl > 255) begin
        lvl = 255;
      end
      flash_level = lvl[7:0];
      flash_left = flash_left - 16'd1;
    end
  endfunction

  function void note_item(in_t item);
    logic [3:0][7:0] goal;
    out_t            due;
    goal = {item.alpha, item.blue, item.green, item.red};
    case (item.command)
      CMD_TICK: begin
        advance_frame();
      end
      CMD_TINT: begin
        begin_tint(goal, item.frames);
      end
      CMD_FADE_IN: begin
        if (item.frames != '0) begin
          tint_now = {FullLevel, item.src_blue, item.src_green, item.src_red};
          begin_tint(goal, item.frames);
        end
      end
      CMD_FADE_OUT: begin
        goal[3] = FullLevel;
        begin_tint(goal, item.frames);
      end
      CMD_FLASH: begin
        if (item.frames != '0) begin
          flash_rgb = {item.blue, item.green, item.red};
          flash_level = '0;
          flash_left = item.frames;
          flash_mid = 16'((17'(item.frames) + 17'd1) >> 1);
        end
      end
      default: begin
      end
    endcase
    due.tint_red      = tint_now[0];
    due.tint_green    = tint_now[1];
    due.tint_blue     = tint_now[2];
    due.tint_alpha    = tint_now[3];
    due.tint_busy     = (tint_left != '0);
    due.flash_red     = flash_rgb[0];
    due.flash_green   = flash_rgb[1];
    due.flash_blue    = flash_rgb[2];
    due.flash_level   = flash_level;
    due.flash_visible = (flash_left != '0);
    overlay_due_q.push_back(due);
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportCap) begin
        $display("%0t: %s expected %h, actual %h", $time, field, want, got);
      end
    end
  endfunction

  function void check_overlay(out_t got);
    out_t want;
    results_seen++;
    if (overlay_due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportCap) begin
        $display("%0t: result with no transaction outstanding, expected none, actual %h",
                 $time, got);
      end
      return;
    end
    want = overlay_due_q.pop_front();
    compare_field("tint_red", want.tint_red, got.tint_red);
    compare_field("tint_green", want.tint_green, got.tint_green);
    compare_field("tint_blue", want.tint_blue, got.tint_blue);
    compare_field("tint_alpha", want.tint_alpha, got.tint_alpha);
    compare_field("tint_busy", want.tint_busy, got.tint_busy);
    compare_field("flash_red", want.flash_red, got.flash_red);
    compare_field("flash_green", want.flash_green, got.flash_green);
    compare_field("flash_blue", want.flash_blue, got.flash_blue);
    compare_field("flash_level", want.flash_level, got.flash_level);
    compare_field("flash_visible", want.flash_visible, got.flash_visible);
  endfunction
endclass

module testbench;
  // The run stops here no matter what; a correct run needs well under a
  // tenth of this even with the heaviest idling on both sides.
  localparam int unsigned CycleLimit   = 1_000_000;
  // Useful transactions in the random part, that is ticks and effect
  // commands that carry frames. Ignored transactions come on top.
  localparam int unsigned RandomItems  = 1400;
  localparam int unsigned SegmentItems = 150;
  // This tail catches any stray late result.
  localparam int unsigned TailCycles   = 64;
  // The command field is three bits wide, so codes above the flash are unused.
  localparam int          CmdCodes     = 8;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  overlay_tracker tracker;

  // Sender and receiver idling controls.
  logic        gaps_on    = 1'b0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  logic [15:0] rx_mask    = 16'hFFFF;
  logic [3:0]  rx_phase   = '0;

  // Transaction tallies for the closing summary.
  int unsigned n_items   = 0;
  int unsigned n_ticks   = 0;
  int unsigned n_effects = 0;
  int unsigned n_ignored = 0;
  int unsigned n_useful  = 0;

  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  screen_tint_and_flash_fader u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // The receiver is either always open, stalls at random, or follows a 16-bit
  // mask chosen per segment. The mask always has at least one open slot.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 4'd1;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_ready <= ($urandom_range(0, 99) >= 40);
      end
      default: begin
        out_ready <= rx_mask[rx_phase];
      end
    endcase
  end

  // Every result transaction is checked against the oldest owed overlay.
  // Signals are read right after the edge, so they hold their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_overlay(out_data);
    end
  end

  // Watchdog: a hung block or a lost result ends the run as a failure.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, tracker.pending());
    $display("screen_tint_and_flash_fader verification failed");
    $finish;
  end

  function automatic logic [15:0] pick_frames();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // Zero makes an effect command a no-op; the near-full values exercise the
    // widest countdowns; short effects let fades and flashes run to the end.
    if (roll < 6) begin
      return '0;
    end
    if (roll < 10) begin
      return 16'($urandom);
    end
    if (roll < 13) begin
      return 16'hFFFF - 16'($urandom_range(0, 3));
    end
    if (roll < 40) begin
      return 16'($urandom_range(1, 4));
    end
    return 16'($urandom_range(1, 24));
  endfunction

  // Any command code with every field random.
  function automatic in_t random_fields();
    in_t item;
    item.command   = 3'($urandom_range(0, CmdCodes - 1));
    item.red       = 8'($urandom);
    item.green     = 8'($urandom);
    item.blue      = 8'($urandom);
    item.alpha     = 8'($urandom);
    item.src_red   = 8'($urandom);
    item.src_green = 8'($urandom);
    item.src_blue  = 8'($urandom);
    item.frames    = pick_frames();
    return item;
  endfunction

  function automatic in_t tick_item();
    in_t item;
    item = random_fields();
    item.command = CMD_TICK;
    return item;
  endfunction

  function automatic in_t effect_item();
    in_t item;
    item = random_fields();
    case ($urandom_range(0, 3))
      0: item.command = CMD_TINT;
      1: item.command = CMD_FADE_IN;
      2: item.command = CMD_FADE_OUT;
      default: item.command = CMD_FLASH;
    endcase
    // Now and then aim at the tint that is already showing, or at its own start
    // color for a fade in; a tint then leaves any running fade alone.
    if ($urandom_range(0, 6) == 0) begin
      if (item.command == CMD_FADE_IN) begin
        {item.alpha, item.blue, item.green, item.red} =
          {FullLevel, item.src_blue, item.src_green, item.src_red};
      end else begin
        {item.alpha, item.blue, item.green, item.red} = tracker.tint_now;
      end
    end
    return item;
  endfunction

  function automatic in_t make_item(cmd_e cmd, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, logic [7:0] a, logic [7:0] sr,
                                    logic [7:0] sg, logic [7:0] sb,
                                    logic [15:0] frames);
    in_t item;
    item.command   = cmd;
    item.red       = r;
    item.green     = g;
    item.blue      = b;
    item.alpha     = a;
    item.src_red   = sr;
    item.src_green = sg;
    item.src_blue  = sb;
    item.frames    = frames;
    return item;
  endfunction

  // Drives one input transaction and waits for its handshake. Valid is raised
  // without looking at ready and held with the payload until accepted. In
  // bursty mode the sender drops valid for a random gap between bursts.
  task automatic send_item(input in_t item);
    int unsigned pause;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      pause = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
    tracker.note_item(item);
    n_items++;
    if (item.command > CMD_FLASH || (item.command != CMD_TICK && item.frames == '0)) begin
      n_ignored++;
    end else if (item.command == CMD_TICK) begin
      n_ticks++;
      n_useful++;
    end else begin
      n_effects++;
      n_useful++;
    end
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic drain_overlays();
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (tracker.pending() != 0);
  endtask

  // Walks through each command and each corner the fader has to handle.
  task automatic run_directed();
    in_t item;
    // A tick with nothing running keeps the reset state.
    send_item(make_item(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    // A tint with zero frames, and one toward the color already shown, do nothing.
    send_item(make_item(CMD_TINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'd0));
    send_item(make_item(CMD_TINT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 16'd7));
    // A one-frame tint jumps all the way in a single tick.
    send_item(make_item(CMD_TINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'd1));
    send_item(tick_item());
    send_item(tick_item());
    // Fade in: zero frames leaves everything alone, then a three-frame fade
    // that moves channels both up and down.
    send_item(make_item(CMD_FADE_IN, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 16'd0));
    send_item(make_item(CMD_FADE_IN, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 16'd3));
    repeat (3) send_item(tick_item());
    // Fade out forces alpha to opaque even when the item asks for zero.
    send_item(make_item(CMD_FADE_OUT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        16'hFFFF));
    send_item(tick_item());
    // A fade in whose start already equals its goal sets the start color,
    // but the long fade out keeps running toward its own goal.
    send_item(make_item(CMD_FADE_IN, 8'h11, 8'h22, 8'h33, 8'hFF, 8'h11, 8'h22, 8'h33, 16'd4));
    send_item(tick_item());
    // A one-frame flash peaks on its only frame; a two-frame flash starts
    // dark and peaks on the second; the longest flash starts low.
    send_item(make_item(CMD_FLASH, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'd1));
    send_item(tick_item());
    send_item(tick_item());
    send_item(make_item(CMD_FLASH, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'd2));
    send_item(tick_item());
    send_item(tick_item());
    send_item(make_item(CMD_FLASH, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
                        16'hFFFF));
    send_item(tick_item());
    // A flash with zero frames leaves the running flash untouched.
    send_item(make_item(CMD_FLASH, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 16'd0));
    // Unused command codes are ignored even with frames attached.
    for (int c = int'(CMD_FLASH) + 1; c < CmdCodes; c++) begin
      item = random_fields();
      item.command = 3'(c);
      item.frames = 16'd9;
      send_item(item);
    end
  endtask

  // Mostly well-formed traffic: one or two effects followed by a run of
  // ticks, long enough to finish most short fades and flashes. The rest is
  // noise with any command code and any field values.
  task automatic run_sequence();
    int unsigned roll;
    int unsigned count;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      count = $urandom_range(1, 2);
      repeat (count) send_item(effect_item());
      count = $urandom_range(1, 30);
      repeat (count) send_item(tick_item());
    end else begin
      count = $urandom_range(1, 6);
      repeat (count) send_item(random_fields());
    end
  endtask

  initial begin
    int unsigned random_goal;
    int unsigned segment_end;
    tracker = new();

    // Reset is held low from time zero and released once, at a clock edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    // The sender pauses here until every result of the directed part is back.
    drain_overlays();

    // The random part runs in segments. Each segment picks its own sender
    // and receiver behavior, so some have no idling at all and others stall
    // on both sides. Some segments end by draining the block completely.
    random_goal = n_useful + RandomItems;
    while (n_useful < random_goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_mask <= 16'($urandom) | 16'h0001;
      segment_end = n_useful + SegmentItems;
      while (n_useful < segment_end && n_useful < random_goal) begin
        run_sequence();
      end
      if ($urandom_range(0, 2) == 0) begin
        drain_overlays();
      end
    end

    // Wait for the last results, then give the block time to show any extra one.
    drain_overlays();
    repeat (TailCycles) @(posedge clk_i);

    $display("Drove %0d transactions: %0d ticks, %0d effect commands, %0d ignored.",
             n_items, n_ticks, n_effects, n_ignored);
    $display("Compared %0d results in %0d cycles with %0d mismatches.",
             tracker.results_seen, cycle_count, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("screen_tint_and_flash_fader verification clean");
    end else begin
      $display("screen_tint_and_flash_fader verification failed");
    end
    $finish;
  end
endmodule
